// ----- src/brb_pkg.sv -----
package brb_pkg;

  localparam int SLOT_COUNT = 4;
  localparam int SLOT_IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int TAG_W = 8;
  localparam int XLEN = 32;
  localparam logic [XLEN-1:0] PC_STEP = XLEN'(4);

  typedef logic [TAG_W-1:0] tag_t;
  typedef logic [XLEN-1:0] addr_t;

  typedef enum logic [2:0] {
    OP_EQ  = 3'd0,
    OP_NE  = 3'd1,
    OP_LT  = 3'd2,
    OP_GE  = 3'd3,
    OP_LTU = 3'd4,
    OP_GEU = 3'd5
  } op_t;

  typedef struct packed {
    logic  valid;
    tag_t  tag;
    addr_t from_pc;
    addr_t target_pc;
  } push_t;

  typedef struct packed {
    logic  valid;
    tag_t  tag;
  } flush_t;

  typedef struct packed {
    logic  valid;
    addr_t from_pc;
    addr_t target_pc;
    tag_t  tag;
    logic  full;
  } head_t;

  // a is older than b when (a - b) mod 2^TAG_W lands in the upper half
  function automatic logic tag_older(input tag_t a, input tag_t b);
    tag_t diff;
    diff = a - b;
    return diff[TAG_W-1];
  endfunction

endpackage

// ----- src/brb_resolve.sv -----
module brb_resolve (
  input  logic                             dispatch_valid,
  input  brb_pkg::tag_t                    dispatch_tag,
  input  logic [2:0]                       operation,
  input  logic signed [brb_pkg::XLEN-1:0]  first_source,
  input  logic signed [brb_pkg::XLEN-1:0]  second_source,
  input  brb_pkg::addr_t                   branch_pc,
  input  logic signed [brb_pkg::XLEN-1:0]  offset,
  output brb_pkg::push_t                   push
);

  logic eq;
  logic lt_s;
  logic lt_u;
  logic taken;

  assign eq   = first_source == second_source;
  assign lt_s = first_source < second_source;
  assign lt_u = unsigned'(first_source) < unsigned'(second_source);

  always_comb begin
    unique case (operation)
      brb_pkg::OP_EQ:  taken = eq;
      brb_pkg::OP_NE:  taken = !eq;
      brb_pkg::OP_LT:  taken = lt_s;
      brb_pkg::OP_GE:  taken = !lt_s;
      brb_pkg::OP_LTU: taken = lt_u;
      brb_pkg::OP_GEU: taken = !lt_u;
      default:         taken = 1'b0;
    endcase
  end

  assign push.valid     = dispatch_valid;
  assign push.tag       = dispatch_tag;
  assign push.from_pc   = branch_pc;
  assign push.target_pc = taken ? branch_pc + unsigned'(offset)
                                : branch_pc + brb_pkg::PC_STEP;

endmodule

// ----- src/brb_slots.sv -----
module brb_slots (
  input  logic           clk,
  input  logic           rst,
  input  logic           step,
  input  brb_pkg::push_t push,
  input  brb_pkg::flush_t flush,
  output brb_pkg::head_t head
);

  logic           slot_valid [brb_pkg::SLOT_COUNT];
  logic           slot_valid_next [brb_pkg::SLOT_COUNT];
  brb_pkg::addr_t slot_from_pc [brb_pkg::SLOT_COUNT];
  brb_pkg::addr_t slot_target_pc [brb_pkg::SLOT_COUNT];
  brb_pkg::tag_t  slot_tag [brb_pkg::SLOT_COUNT];

  logic                          found;
  logic [brb_pkg::SLOT_IDX_W-1:0] best;
  logic                          has_free;
  logic [brb_pkg::SLOT_IDX_W-1:0] free_idx;
  logic                          do_push;
  logic                          push_flushed;

  // oldest entry, lowest slot wins ties; lowest free slot
  always_comb begin
    found    = 1'b0;
    best     = '0;
    has_free = 1'b0;
    free_idx = '0;
    for (int i = 0; i < brb_pkg::SLOT_COUNT; i++) begin
      if (slot_valid[i]) begin
        if (!found || brb_pkg::tag_older(slot_tag[i], slot_tag[best])) begin
          best = brb_pkg::SLOT_IDX_W'(i);
        end
        found = 1'b1;
      end else if (!has_free) begin
        has_free = 1'b1;
        free_idx = brb_pkg::SLOT_IDX_W'(i);
      end
    end
  end

  assign head.valid     = found;
  assign head.from_pc   = found ? slot_from_pc[best] : '0;
  assign head.target_pc = found ? slot_target_pc[best] : '0;
  assign head.tag       = found ? slot_tag[best] : '0;
  assign head.full      = !has_free;

  assign do_push      = push.valid && has_free;
  assign push_flushed = flush.valid && !brb_pkg::tag_older(push.tag, flush.tag);

  always_comb begin
    for (int i = 0; i < brb_pkg::SLOT_COUNT; i++) begin
      if (do_push && free_idx == brb_pkg::SLOT_IDX_W'(i)) begin
        slot_valid_next[i] = !push_flushed;
      end else begin
        slot_valid_next[i] = slot_valid[i]
          && !(found && slot_tag[i] == head.tag)
          && !(flush.valid && !brb_pkg::tag_older(slot_tag[i], flush.tag));
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < brb_pkg::SLOT_COUNT; i++) begin
      if (rst) begin
        slot_valid[i] <= 1'b0;
      end else if (step) begin
        slot_valid[i] <= slot_valid_next[i];
      end
      if (step && do_push && free_idx == brb_pkg::SLOT_IDX_W'(i)) begin
        slot_from_pc[i]   <= push.from_pc;
        slot_target_pc[i] <= push.target_pc;
        slot_tag[i]       <= push.tag;
      end
    end
  end

endmodule

// ----- src/branch_resolve_buffer_top.sv -----
// channel  | handshake                  | payload
// request  | req_valid / req_stall      | dispatch_*, operation, sources, branch_pc, offset, squash*
// result   | result_valid / result_stall | head_valid, head_from_pc, head_target_pc, head_tag, all_full
//
// one request per cycle sustained while the result is not stalled; a request is registered,
// then resolved against the slot state and its result registered when it advances.
// the slot update and result register share one advance enable.
// synchronous reset empties all slots and both register stages.
// result_stall holds the result register; req_stall rises only while both stages are full.
module branch_resolve_buffer_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            req_valid,
  output logic                            req_stall,
  input  logic                            dispatch_valid,
  input  logic [7:0]                      dispatch_tag,
  input  logic [2:0]                      operation,
  input  logic signed [31:0]              first_source,
  input  logic signed [31:0]              second_source,
  input  logic [31:0]                     branch_pc,
  input  logic signed [31:0]              offset,
  input  logic                            squash,
  input  logic [7:0]                      squash_tag,
  output logic                            result_valid,
  input  logic                            result_stall,
  output logic                            head_valid,
  output logic [31:0]                     head_from_pc,
  output logic [31:0]                     head_target_pc,
  output logic [7:0]                      head_tag,
  output logic                            all_full
);

  logic               req_full;
  logic               q_dispatch_valid;
  logic [7:0]         q_dispatch_tag;
  logic [2:0]         q_operation;
  logic signed [31:0] q_first_source;
  logic signed [31:0] q_second_source;
  logic [31:0]        q_branch_pc;
  logic signed [31:0] q_offset;
  logic               q_squash;
  logic [7:0]         q_squash_tag;

  logic            advance;
  logic            take;
  brb_pkg::push_t  push;
  brb_pkg::flush_t flush;
  brb_pkg::head_t  head;

  assign advance   = req_full && (!result_valid || !result_stall);
  assign req_stall = req_full && !advance;
  assign take      = req_valid && !req_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_full <= 1'b0;
    end else if (take) begin
      req_full <= 1'b1;
    end else if (advance) begin
      req_full <= 1'b0;
    end
    if (take) begin
      q_dispatch_valid <= dispatch_valid;
      q_dispatch_tag   <= dispatch_tag;
      q_operation      <= operation;
      q_first_source   <= first_source;
      q_second_source  <= second_source;
      q_branch_pc      <= branch_pc;
      q_offset         <= offset;
      q_squash         <= squash;
      q_squash_tag     <= squash_tag;
    end
  end

  brb_resolve u_resolve (
    .dispatch_valid (q_dispatch_valid),
    .dispatch_tag   (q_dispatch_tag),
    .operation      (q_operation),
    .first_source   (q_first_source),
    .second_source  (q_second_source),
    .branch_pc      (q_branch_pc),
    .offset         (q_offset),
    .push           (push)
  );

  assign flush.valid = q_squash;
  assign flush.tag   = q_squash_tag;

  brb_slots u_slots (
    .clk   (clk),
    .rst   (rst),
    .step  (advance),
    .push  (push),
    .flush (flush),
    .head  (head)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
    if (advance) begin
      head_valid     <= head.valid;
      head_from_pc   <= head.from_pc;
      head_target_pc <= head.target_pc;
      head_tag       <= head.tag;
      all_full       <= head.full;
    end
  end

endmodule

// ----- src/brb_checker.sv -----
module brb_checker (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_stall,
  input logic        result_valid,
  input logic        result_stall,
  input logic        head_valid,
  input logic [31:0] head_from_pc,
  input logic [31:0] head_target_pc,
  input logic [7:0]  head_tag,
  input logic        all_full
);

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !result_valid && !req_stall)
    else $error("result or stall left set after reset");

  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> result_valid && result_stall)
    else $error("request stalled without a stalled result");

  a_full_has_head: assert property (@(posedge clk) disable iff (rst)
    result_valid && all_full |-> head_valid)
    else $error("full buffer reported with no head");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !head_valid |->
      head_tag == 8'd0 && head_from_pc == 32'd0 && head_target_pc == 32'd0)
    else $error("empty head carries nonzero fields");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid)
    else $error("stalled result dropped");

endmodule

bind branch_resolve_buffer_top brb_checker u_brb_checker (.*);
